// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define FAWC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Concurrent assertion that is checked during reset as well.
`define FAWC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/fawc_pkg.sv =====
// Package with the types and constants of the word cache.
`default_nettype none

package fawc_pkg;

  localparam int NUM_ENTRIES = 256;
  localparam int RED_WIDTH   = 32;
  localparam int NUM_GROUPS  = (NUM_ENTRIES + RED_WIDTH - 1) / RED_WIDTH;
  localparam int TAG_W       = 30;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_UPD
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] word;
  } line_t;

  typedef struct packed {
    logic              shift;
    logic              update;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fawc_if.sv =====
// Request and response channel interfaces of the word cache.
`default_nettype none

interface fawc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] addr;
  logic [31:0] write_data;
  logic [31:0] fill_data;

  modport source (output valid, req_type, addr, write_data, fill_data, input ready);
  modport sink   (input valid, req_type, addr, write_data, fill_data, output ready);
endinterface

interface fawc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        hit;
  logic        mem_write_en;
  logic [31:0] mem_write_addr;
  logic [31:0] mem_write_data;

  modport source (output valid, read_data, hit, mem_write_en, mem_write_addr,
                  mem_write_data, input ready);
  modport sink   (input valid, read_data, hit, mem_write_en, mem_write_addr,
                  mem_write_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fawc_cell.sv =====
// One cache line cell of the shifting line chain, with its tag compare.
`default_nettype none

module fawc_cell (
  input  logic                clk,
  input  logic                rst,
  input  fawc_pkg::cell_ctrl_t ctrl,
  input  fawc_pkg::line_t     prev,
  output fawc_pkg::line_t     line,
  output logic                match,
  output logic [31:0]         mword
);
  import fawc_pkg::*;

  logic eq;

  assign eq = line.valid && (line.tag == ctrl.tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      line.valid <= 1'b0;
    end else if (ctrl.shift) begin
      line.valid <= prev.valid;
    end
    if (ctrl.shift) begin
      line.tag  <= prev.tag;
      line.word <= prev.word;
    end else if (ctrl.update && match) begin
      line.word <= ctrl.word;
    end
  end

  always_ff @(posedge clk) begin
    match <= eq;
    mword <= eq ? line.word : '0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fawc_reduce.sv =====
// Registered OR reduction of match flags and masked words over one group.
`default_nettype none

module fawc_reduce (
  input  logic                            clk,
  input  logic [fawc_pkg::RED_WIDTH-1:0]  hit_in,
  input  logic [31:0]                     word_in [fawc_pkg::RED_WIDTH],
  output logic                            any_q,
  output logic [31:0]                     word_q
);
  import fawc_pkg::*;

  logic [31:0] word_or;

  always_comb begin
    word_or = '0;
    for (int i = 0; i < RED_WIDTH; i++) begin
      word_or = word_or | word_in[i];
    end
  end

  always_ff @(posedge clk) begin
    any_q  <= |hit_in;
    word_q <= word_or;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_fully_assoc_word_cache.sv =====
// Top level of the fully associative word cache with FIFO replacement.
//
// The req channel carries one access: req_type (0 read, 1 write), the byte
// address, the write word and the memory word used to fill on a read miss.
// The rsp channel returns one transfer per access: the read word, the hit
// flag and the write-through to memory (address and data on writes, zero on
// reads). Both channels transfer when valid and ready are high together.
// Lines sit in a chain of cells. A miss shifts a new line into the head of
// the chain and the oldest line drops off the tail, which is the FIFO order.
// An access runs from request transfer to response valid through the
// registered tag compare in every cell, the registered group and top levels
// of the match reduction tree, and the chain update. A new request is taken
// only while idle or in the update step of the access before it.
// Reset clears every valid bit at once; tags and words need no clearing.
// While the receiver stalls, the response is held and the block finishes
// the next access up to its update step and then waits.
`default_nettype none

module fifo_fully_assoc_word_cache (
  input  logic       clk,
  input  logic       rst,
  fawc_req_if.sink   req,
  fawc_rsp_if.source rsp
);
  import fawc_pkg::*;

  state_t      state;
  state_t      state_next;
  logic        req_write;
  logic [31:0] req_addr;
  logic [31:0] req_wdata;
  logic [31:0] req_fdata;
  logic        out_free;
  logic        go;
  logic        accept;
  cell_ctrl_t  ctrl;
  line_t       head;
  line_t       lines [NUM_ENTRIES];
  logic        match [NUM_ENTRIES];
  logic [31:0] mword [NUM_ENTRIES];
  logic [RED_WIDTH-1:0] grp_hit_in [NUM_GROUPS];
  logic [31:0] grp_word_in [NUM_GROUPS][RED_WIDTH];
  logic        grp_hit [NUM_GROUPS];
  logic [31:0] grp_word [NUM_GROUPS];
  logic [RED_WIDTH-1:0] top_hit_in;
  logic [31:0] top_word_in [RED_WIDTH];
  logic        hit_q;
  logic [31:0] hit_word_q;

  assign out_free  = !rsp.valid || rsp.ready;
  assign go        = (state == S_UPD) && out_free;
  assign req.ready = (state == S_IDLE) || go;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP:  state_next = S_RED1;
      S_RED1: state_next = S_RED2;
      S_RED2: state_next = S_UPD;
      S_UPD: begin
        if (go) state_next = accept ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_write <= req.req_type;
      req_addr  <= req.addr;
      req_wdata <= req.write_data;
      req_fdata <= req.fill_data;
    end
  end

  always_comb begin
    ctrl.shift  = go && !hit_q;
    ctrl.update = go && hit_q && req_write;
    ctrl.tag    = req_addr[31:2];
    ctrl.word   = req_wdata;
    head.valid  = 1'b1;
    head.tag    = req_addr[31:2];
    head.word   = req_write ? req_wdata : req_fdata;
  end

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      fawc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .prev  (head),
        .line  (lines[i]),
        .match (match[i]),
        .mword (mword[i])
      );
    end else begin : g_body
      fawc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .prev  (lines[i-1]),
        .line  (lines[i]),
        .match (match[i]),
        .mword (mword[i])
      );
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int j = 0; j < RED_WIDTH; j++) begin
        if (g * RED_WIDTH + j < NUM_ENTRIES) begin
          grp_hit_in[g][j]  = match[g * RED_WIDTH + j];
          grp_word_in[g][j] = mword[g * RED_WIDTH + j];
        end else begin
          grp_hit_in[g][j]  = 1'b0;
          grp_word_in[g][j] = '0;
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    fawc_reduce u_reduce (
      .clk     (clk),
      .hit_in  (grp_hit_in[g]),
      .word_in (grp_word_in[g]),
      .any_q   (grp_hit[g]),
      .word_q  (grp_word[g])
    );
  end

  always_comb begin
    for (int j = 0; j < RED_WIDTH; j++) begin
      if (j < NUM_GROUPS) begin
        top_hit_in[j]  = grp_hit[j];
        top_word_in[j] = grp_word[j];
      end else begin
        top_hit_in[j]  = 1'b0;
        top_word_in[j] = '0;
      end
    end
  end

  fawc_reduce u_reduce_top (
    .clk     (clk),
    .hit_in  (top_hit_in),
    .word_in (top_word_in),
    .any_q   (hit_q),
    .word_q  (hit_word_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.hit            <= hit_q;
      rsp.mem_write_en   <= req_write;
      rsp.mem_write_addr <= req_write ? req_addr : '0;
      rsp.mem_write_data <= req_write ? req_wdata : '0;
      if (req_write) begin
        rsp.read_data <= '0;
      end else begin
        rsp.read_data <= hit_q ? hit_word_q : req_fdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fawc_checker.sv =====
// Port-level checker of the word cache and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module fawc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] read_data,
  input logic        mem_write_en,
  input logic [31:0] mem_write_addr,
  input logic [31:0] mem_write_data
);

  logic req_xfer;
  logic wt_zero;

  assign req_xfer = req_valid && req_ready;
  assign wt_zero  = (mem_write_addr == 32'd0) && (mem_write_data == 32'd0);

  `FAWC_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)
  `FAWC_ASSERT(a_read_no_write, clk, rst, rsp_valid && !mem_write_en |-> wt_zero)
  `FAWC_ASSERT(a_write_no_data, clk, rst, rsp_valid && mem_write_en |-> read_data == 32'd0)
  `FAWC_ASSERT_ALWAYS(a_req_spacing, clk, req_xfer && !rst |=> !req_xfer)

endmodule

bind fifo_fully_assoc_word_cache fawc_checker u_fawc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .read_data      (rsp.read_data),
  .mem_write_en   (rsp.mem_write_en),
  .mem_write_addr (rsp.mem_write_addr),
  .mem_write_data (rsp.mem_write_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench that checks the word cache against a predictor of its lines and FIFO pointer.
`timescale 1ns / 1ps

module testbench;
  import fawc_pkg::*;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_t;

  typedef struct {
    access_kind_t kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] fill_data;
  } access_t;

  typedef struct {
    logic [WORD_W-1:0] read_data;
    logic hit;
    logic mem_write_en;
    logic [ADDR_W-1:0] mem_write_addr;
    logic [WORD_W-1:0] mem_write_data;
  } cache_result_t;

  localparam int RANDOM_ACCESSES = 1000;
  localparam int POOL_SIZE = 320;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;

  fawc_req_if req_ch ();
  fawc_rsp_if rsp_ch ();

  fifo_fully_assoc_word_cache dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  access_t pending_accesses[$];
  cache_result_t expected_results[$];
  int total_accesses;
  int num_accepted = 0;
  int error_count = 0;
  int stall_cycles = 0;

  bit line_valid[NUM_ENTRIES];
  logic [TAG_W-1:0] line_tag[NUM_ENTRIES];
  logic [WORD_W-1:0] line_word[NUM_ENTRIES];
  int fifo_ptr = 0;

  logic [TAG_W-1:0] tag_pool[POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic cache_result_t access_cache(access_t a);
    cache_result_t r;
    logic [TAG_W-1:0] t;
    int slot;
    t = a.addr[ADDR_W-1:2];
    slot = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (slot < 0 && line_valid[i] && line_tag[i] == t) slot = i;
    end
    r.hit = (slot >= 0);
    if (slot < 0) begin
      slot = fifo_ptr;
      line_valid[slot] = 1'b1;
      line_tag[slot] = t;
      line_word[slot] = (a.kind == ACC_WRITE) ? a.write_data : a.fill_data;
      fifo_ptr = (fifo_ptr + 1) % NUM_ENTRIES;
    end else if (a.kind == ACC_WRITE) begin
      line_word[slot] = a.write_data;
    end
    r.read_data = (a.kind == ACC_READ) ? line_word[slot] : '0;
    r.mem_write_en = (a.kind == ACC_WRITE);
    r.mem_write_addr = (a.kind == ACC_WRITE) ? a.addr : '0;
    r.mem_write_data = (a.kind == ACC_WRITE) ? a.write_data : '0;
    return r;
  endfunction

  function automatic void queue_access(access_kind_t kind, logic [31:0] addr,
                                       logic [31:0] write_data, logic [31:0] fill_data);
    access_t a;
    a.kind = kind;
    a.addr = addr;
    a.write_data = write_data;
    a.fill_data = fill_data;
    pending_accesses.push_back(a);
  endfunction

  function automatic int idle_pct(bit sender);
    if (num_accepted < total_accesses / 3) return sender ? 30 : 59;
    if (num_accepted < 2 * total_accesses / 3) return sender ? 59 : 30;
    return 0;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    access_t a;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_accesses.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        a = pending_accesses.pop_front();
        req_ch.req_type <= a.kind;
        req_ch.addr <= a.addr;
        req_ch.write_data <= a.write_data;
        req_ch.fill_data <= a.fill_data;
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    access_t a;
    cache_result_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        a.kind = access_kind_t'(req_ch.req_type);
        a.addr = req_ch.addr;
        a.write_data = req_ch.write_data;
        a.fill_data = req_ch.fill_data;
        expected_results.push_back(access_cache(a));
        num_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("response transfer with no access outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", want.read_data, rsp_ch.read_data);
          compare_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
          compare_field("mem_write_en", 32'(want.mem_write_en), 32'(rsp_ch.mem_write_en));
          compare_field("mem_write_addr", want.mem_write_addr, rsp_ch.mem_write_addr);
          compare_field("mem_write_data", want.mem_write_data, rsp_ch.mem_write_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] addr;
    rst = 1'b1;

    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = TAG_W'($urandom);

    // Misses, hits through ignored low address bits, write hits and write misses.
    queue_access(ACC_READ, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_access(ACC_READ, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_access(ACC_WRITE, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_access(ACC_READ, 32'h0000_0002, 32'h1234_5678, 32'h8765_4321);
    queue_access(ACC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_access(ACC_READ, 32'hFFFF_FFFC, 32'h0000_0000, 32'h0000_0000);
    queue_access(ACC_WRITE, 32'hFFFF_FFFE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_access(ACC_READ, 32'hFFFF_FFFD, 32'h0000_0000, 32'h0000_0000);
    queue_access(ACC_READ, 32'h8000_0000, 32'h0000_0000, 32'h5A5A_5A5A);
    queue_access(ACC_READ, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_access(ACC_READ, 32'h7FFF_FFFC, 32'hFFFF_FFFF, 32'h1234_5678);
    queue_access(ACC_WRITE, 32'h0000_0004, 32'hDEAD_BEEF, 32'h0000_0000);
    queue_access(ACC_READ, 32'h0000_0007, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_access(ACC_WRITE, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_access(ACC_READ, 32'h7FFF_FFFC, 32'h0000_0000, 32'h0000_0000);
    queue_access(ACC_WRITE, 32'h8000_0003, 32'h8000_0000, 32'h0000_0000);
    queue_access(ACC_READ, 32'h8000_0001, 32'h0000_0000, 32'h0000_0000);

    // Most random accesses reuse a pool a bit larger than the cache, so both hits and
    // FIFO replacement of live lines occur; the rest go to arbitrary addresses.
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if ($urandom_range(99) < 65) addr = {tag_pool[$urandom_range(POOL_SIZE - 1)], 2'(
          $urandom)};
      else addr = $urandom;
      queue_access(access_kind_t'($urandom_range(1)), addr, $urandom, $urandom);
    end
    total_accesses = pending_accesses.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_accesses.size() != 0 || req_ch.valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
